// File: hdl/lprl_pkg.sv
`timescale 1ns / 1ps

package lprl_pkg;

    // Default table depth
    localparam int DEF_TABLE_DEPTH = 16;

    // Slots reachable through the 4-bit entry index
    localparam int INDEX_SLOTS = 16;

    // Reset value of the default route exception address (10.0.1.100)
    localparam logic [31:0] EXCEPTION_RESET = 32'h0A00_0164;

    // Action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_RESULT
    } lprl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic write;   // store the entry of the accepted beat
        logic load;    // start a lookup: latch address, clear best match
        logic walk;    // read the slot under the walk counter, advance it
        logic finish;  // qualify best match and present the result
    } lprl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic walk_last;  // walk counter sits on the last slot
    } lprl_status_t;

endpackage

// File: hdl/lprl_ctrl.sv
`timescale 1ns / 1ps

module lprl_ctrl
    import lprl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         action,
    input  lprl_status_t status,
    output logic         busy,
    output lprl_cmd_t    cmd
);

    lprl_state_t state_reg;
    lprl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_LAST;
                end
            end
            // last slot is evaluated here
            ST_LAST:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lprl_datapath.sv
`timescale 1ns / 1ps

module lprl_datapath
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  lprl_cmd_t    cmd,
    output lprl_status_t status,
    // entry and lookup fields
    input  logic [3:0]   entry_index,
    input  logic         entry_valid,
    input  logic [31:0]  route_dest,
    input  logic [31:0]  route_mask,
    input  logic [31:0]  route_gateway,
    input  logic [3:0]   route_iface,
    input  logic [31:0]  lookup_addr,
    // configuration
    input  logic         cfg_valid,
    input  logic [31:0]  cfg_data,
    // result
    output logic         done,
    output logic         found,
    output logic [31:0]  next_hop,
    output logic [3:0]   out_iface,
    output logic [5:0]   prefix_len
);

    // Only slots an entry index can reach are ever valid
    localparam int SLOTS = (TABLE_DEPTH < INDEX_SLOTS) ? TABLE_DEPTH : INDEX_SLOTS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Table memories
    logic [31:0] dest_mem    [SLOTS];
    logic [31:0] mask_mem    [SLOTS];
    logic [31:0] gateway_mem [SLOTS];
    logic [3:0]  iface_mem   [SLOTS];
    logic        valid_reg   [SLOTS];

    logic [IDX_W-1:0] cnt_reg;
    logic             eval_reg;
    logic [31:0]      rd_dest_reg;
    logic [31:0]      rd_mask_reg;
    logic [31:0]      rd_gw_reg;
    logic [3:0]       rd_if_reg;
    logic             rd_valid_reg;

    logic [31:0]      exc_reg;
    logic [31:0]      addr_reg;
    logic             have_reg;
    logic [5:0]       best_len_reg;
    logic [31:0]      best_gw_reg;
    logic [3:0]       best_if_reg;

    logic             done_reg;
    logic             found_reg;
    logic [31:0]      next_hop_reg;
    logic [3:0]       out_iface_reg;
    logic [5:0]       prefix_len_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [5:0]       rd_len;
    logic             hit;
    logic             take;
    logic             usable;

    assign wr_en  = cmd.write && ({28'd0, entry_index} < 32'(TABLE_DEPTH));
    assign wr_idx = entry_index[IDX_W-1:0];

    assign status.walk_last = (cnt_reg == LAST_IDX);

    // Leading run of ones in the read mask
    always_comb
    begin
        logic [31:0] hi;
        rd_len = 6'd0;
        for (int k = 1; k <= 32; k++)
        begin
            hi = 32'hFFFF_FFFF << (32 - k);
            if ((rd_mask_reg & hi) == hi)
            begin
                rd_len = 6'(k);
            end
        end
    end

    // Match and replace decision for the slot under evaluation
    assign hit    = rd_valid_reg && (((addr_reg ^ rd_dest_reg) & rd_mask_reg) == 32'd0);
    assign take   = eval_reg && hit && (!have_reg || (rd_len > best_len_reg));
    assign usable = have_reg && ((best_len_reg != 6'd0) || (addr_reg == exc_reg));

    // Table write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dest_mem[wr_idx]    <= route_dest;
            mask_mem[wr_idx]    <= route_mask;
            gateway_mem[wr_idx] <= route_gateway;
            iface_mem[wr_idx]   <= route_iface;
        end
        if (cmd.walk)
        begin
            rd_dest_reg <= dest_mem[cnt_reg];
            rd_mask_reg <= mask_mem[cnt_reg];
            rd_gw_reg   <= gateway_mem[cnt_reg];
            rd_if_reg   <= iface_mem[cnt_reg];
        end
    end

    // Valid bits, walk control, exception register, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            cnt_reg      <= '0;
            eval_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
            exc_reg      <= EXCEPTION_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= entry_valid;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.walk)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (cmd.walk)
            begin
                rd_valid_reg <= valid_reg[cnt_reg];
            end
            eval_reg <= cmd.walk;
            if (cmd.load)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
            if (cfg_valid)
            begin
                exc_reg <= cfg_data;
            end
            done_reg <= cmd.finish;
        end
    end

    // Lookup address, best match and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= lookup_addr;
        end
        if (take)
        begin
            best_len_reg <= rd_len;
            best_gw_reg  <= rd_gw_reg;
            best_if_reg  <= rd_if_reg;
        end
        if (cmd.finish)
        begin
            found_reg      <= usable;
            next_hop_reg   <= usable ? best_gw_reg  : 32'd0;
            out_iface_reg  <= usable ? best_if_reg  : 4'd0;
            prefix_len_reg <= usable ? best_len_reg : 6'd0;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign next_hop   = next_hop_reg;
    assign out_iface  = out_iface_reg;
    assign prefix_len = prefix_len_reg;

`ifndef SYNTH
    // a finish command always yields a strobe next cycle
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done_reg)
        else $error("finish not followed by result strobe");

    // a zero-length hit is only reported for the exception address
    a_default_exc: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg && (prefix_len_reg == 6'd0)) |-> (addr_reg == exc_reg))
        else $error("default route accepted for non-exception address");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |->
            ((next_hop_reg == 32'd0) && (out_iface_reg == 4'd0) && (prefix_len_reg == 6'd0)))
        else $error("miss with non-zero payload");

    // a slot is evaluated only in the cycle after it was read
    a_eval_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        eval_reg |-> $past(cmd.walk))
        else $error("evaluation without a preceding read");
`endif

endmodule

// File: hdl/longest_prefix_route_lookup.sv
`timescale 1ns / 1ps

// Longest-prefix route lookup over a small IPv4 routing table.
// Command channel: a beat is taken at a rising edge with start high and
// busy low. action selects a table write (entry_index, entry_valid,
// route_dest/mask/gateway/iface) or a lookup of lookup_addr.
// A write completes on the accepting edge, busy stays low and no result
// is produced; writes beyond the table depth are dropped.
// A lookup walks the table one slot per cycle through a single read
// port, over the table depth capped at the 16 slots the index reaches;
// busy stays high in ST_WALK, ST_LAST and ST_RESULT and the result
// follows as a one-cycle done strobe. A new command may be taken in
// the strobe cycle.
// Results: found, next_hop, out_iface, prefix_len, valid with done only.
// The receiver cannot stall; each result is presented once.
// Config channel: cfg_valid/cfg_ready write the default route exception
// address; cfg_ready is always high. Write it only while idle.
// Reset: clears all valid bits and loads the exception address
// 10.0.1.100; no clearing pass is needed.
module longest_prefix_route_lookup
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    input  logic [31:0] route_dest,
    input  logic [31:0] route_mask,
    input  logic [31:0] route_gateway,
    input  logic [3:0]  route_iface,
    input  logic [31:0] lookup_addr,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic        found,
    output logic [31:0] next_hop,
    output logic [3:0]  out_iface,
    output logic [5:0]  prefix_len
);

    lprl_cmd_t    cmd;
    lprl_status_t status;

    assign cfg_ready = 1'b1;

    // Controller
    lprl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Table and match datapath
    lprl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (entry_index),
        .entry_valid   (entry_valid),
        .route_dest    (route_dest),
        .route_mask    (route_mask),
        .route_gateway (route_gateway),
        .route_iface   (route_iface),
        .lookup_addr   (lookup_addr),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .found         (found),
        .next_hop      (next_hop),
        .out_iface     (out_iface),
        .prefix_len    (prefix_len)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lprl_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 10;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 226;
    localparam int QUIET_TAIL  = 150;       // final items sent back to back
    localparam int SETTLE_CYC  = 20;        // longer than a full lookup at the default depth
    localparam int TIMEOUT_NS  = 2_000_000;
    localparam int DIR_ROWS    = 27;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_LOOKUP,
        ROW_LOOKUP_KNOWN,
        ROW_SET_EXC
    } row_kind_t;

    typedef struct packed {
        logic        action;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  iface;
        logic [31:0] addr;
    } route_cmd_t;

    typedef struct packed {
        logic        found;
        logic [31:0] next_hop;
        logic [3:0]  out_iface;
        logic [5:0]  prefix_len;
    } route_result_t;

    typedef struct packed {
        row_kind_t     kind;
        route_cmd_t    cmd;
        logic [31:0]   exc_value;
        route_result_t known;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] route_dest;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [3:0]  route_iface;
    logic [31:0] lookup_addr;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        done;
    logic        found;
    logic [31:0] next_hop;
    logic [3:0]  out_iface;
    logic [5:0]  prefix_len;

    // Shadow routing table and exception address
    logic [31:0] tab_dest  [INDEX_SLOTS];
    logic [31:0] tab_mask  [INDEX_SLOTS];
    logic [31:0] tab_gw    [INDEX_SLOTS];
    logic [3:0]  tab_iface [INDEX_SLOTS];
    logic        tab_valid [INDEX_SLOTS];
    logic [31:0] exc_addr;

    route_result_t route_q [$];
    int            mismatches = 0;
    dir_row_t      dir_tab [DIR_ROWS];

    longest_prefix_route_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .entry_index   (entry_index),
        .entry_valid   (entry_valid),
        .route_dest    (route_dest),
        .route_mask    (route_mask),
        .route_gateway (route_gateway),
        .route_iface   (route_iface),
        .lookup_addr   (lookup_addr),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .found         (found),
        .next_hop      (next_hop),
        .out_iface     (out_iface),
        .prefix_len    (prefix_len)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run of leading ones in a mask
    function automatic logic [5:0] prefix_ones(logic [31:0] m);
        int n;
        n = 0;
        while (n < 32 && m[31 - n])
            n++;
        return n[5:0];
    endfunction

    // Longest match over the shadow table, lowest slot wins a tie
    function automatic route_result_t predict_route(logic [31:0] addr);
        route_result_t best;
        logic          have;
        logic [5:0]    len;
        best = '0;
        have = 1'b0;
        for (int i = 0; i < INDEX_SLOTS; i++)
        begin
            if (tab_valid[i] && ((addr & tab_mask[i]) == (tab_dest[i] & tab_mask[i])))
            begin
                len = prefix_ones(tab_mask[i]);
                if (!have || len > best.prefix_len)
                begin
                    have            = 1'b1;
                    best.prefix_len = len;
                    best.next_hop   = tab_gw[i];
                    best.out_iface  = tab_iface[i];
                end
            end
        end
        // default route only counts for the exception address
        if (have && best.prefix_len == 6'd0 && addr != exc_addr)
            have = 1'b0;
        if (have)
            best.found = 1'b1;
        else
            best = '0;
        return best;
    endfunction

    function automatic dir_row_t mk_write(logic [3:0] idx, logic v, logic [31:0] d, m, g,
                                          logic [3:0] ifc);
        dir_row_t r;
        r                 = '0;
        r.kind            = ROW_WRITE;
        r.cmd.action      = ACT_WRITE;
        r.cmd.entry_index = idx;
        r.cmd.entry_valid = v;
        r.cmd.dest        = d;
        r.cmd.mask        = m;
        r.cmd.gateway     = g;
        r.cmd.iface       = ifc;
        return r;
    endfunction

    function automatic dir_row_t mk_lookup(logic [31:0] a);
        dir_row_t r;
        r          = '0;
        r.kind     = ROW_LOOKUP;
        r.cmd.action = ACT_LOOKUP;
        r.cmd.addr = a;
        return r;
    endfunction

    function automatic dir_row_t mk_known(logic [31:0] a, logic f, logic [31:0] g,
                                          logic [3:0] ifc, logic [5:0] len);
        dir_row_t r;
        r                  = mk_lookup(a);
        r.kind             = ROW_LOOKUP_KNOWN;
        r.known.found      = f;
        r.known.next_hop   = g;
        r.known.out_iface  = ifc;
        r.known.prefix_len = len;
        return r;
    endfunction

    function automatic dir_row_t mk_exc(logic [31:0] v);
        dir_row_t r;
        r           = '0;
        r.kind      = ROW_SET_EXC;
        r.exc_value = v;
        return r;
    endfunction

    // Random beat: mostly prefix-shaped writes and lookups aimed at the table
    function automatic route_cmd_t random_item();
        route_cmd_t c;
        int         pick;
        int         slot;
        c.entry_index = 4'($urandom_range(0, 15));
        c.entry_valid = 1'($urandom_range(0, 1));
        c.dest        = $urandom;
        c.mask        = $urandom;
        c.gateway     = $urandom;
        c.iface       = 4'($urandom_range(0, 15));
        c.addr        = $urandom;
        pick          = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 40)
        begin
            c.action      = ACT_WRITE;
            c.entry_valid = ($urandom_range(0, 99) < 85);
            if (pick < 70)
                c.mask = 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
            else if (pick < 80)
                c.mask = 32'h0;
        end
        else
        begin
            c.action = ACT_LOOKUP;
            if (pick < 50)
            begin
                slot   = $urandom_range(0, INDEX_SLOTS - 1);
                c.addr = (tab_dest[slot] & tab_mask[slot]) | ($urandom & ~tab_mask[slot]);
            end
            else if (pick < 65)
                c.addr = exc_addr;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // One command beat; expectation queued at the accepting edge
    task automatic send_item(input route_cmd_t c, input logic use_known,
                             input route_result_t known);
        action        = c.action;
        entry_index   = c.entry_index;
        entry_valid   = c.entry_valid;
        route_dest    = c.dest;
        route_mask    = c.mask;
        route_gateway = c.gateway;
        route_iface   = c.iface;
        lookup_addr   = c.addr;
        start         = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (c.action == ACT_WRITE)
        begin
            tab_dest[c.entry_index]  = c.dest;
            tab_mask[c.entry_index]  = c.mask;
            tab_gw[c.entry_index]    = c.gateway;
            tab_iface[c.entry_index] = c.iface;
            tab_valid[c.entry_index] = c.entry_valid;
        end
        else
            route_q.push_back(use_known ? known : predict_route(c.addr));
        @(negedge clk);
    endtask

    task automatic idle_gap();
        start = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    // Wait for every queued result, then a short settle
    task automatic drain_results();
        start = 1'b0;
        while (route_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_exception(input logic [31:0] v);
        drain_results();
        cfg_data  = v;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        exc_addr = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Result checker: one strobe, one expectation
    always @(posedge clk)
    begin : result_check
        route_result_t want;
        if (rst_n && done)
        begin
            if (route_q.size() == 0)
                report_mismatch("result with nothing pending", {31'd0, found}, 32'd0);
            else
            begin
                want = route_q.pop_front();
                if (found !== want.found)
                    report_mismatch("found", {31'd0, found}, {31'd0, want.found});
                if (next_hop !== want.next_hop)
                    report_mismatch("next_hop", next_hop, want.next_hop);
                if (out_iface !== want.out_iface)
                    report_mismatch("out_iface", {28'd0, out_iface}, {28'd0, want.out_iface});
                if (prefix_len !== want.prefix_len)
                    report_mismatch("prefix_len", {26'd0, prefix_len},
                                    {26'd0, want.prefix_len});
            end
        end
    end

    // Stimulus
    initial
    begin
        int         total;
        int         sent;
        route_cmd_t c;
        logic [31:0] phase_exc;

        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ACT_WRITE;
        entry_index   = '0;
        entry_valid   = 1'b0;
        route_dest    = '0;
        route_mask    = '0;
        route_gateway = '0;
        route_iface   = '0;
        lookup_addr   = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        for (int i = 0; i < INDEX_SLOTS; i++)
        begin
            tab_dest[i]  = '0;
            tab_mask[i]  = '0;
            tab_gw[i]    = '0;
            tab_iface[i] = '0;
            tab_valid[i] = 1'b0;
        end
        exc_addr = EXCEPTION_RESET;

        // Directed rows; results typed in where obvious
        dir_tab = '{
            mk_known(32'h0000_0000, 1'b0, 32'h0, 4'h0, 6'd0),   // empty table
            mk_known(32'h0A00_0164, 1'b0, 32'h0, 4'h0, 6'd0),   // exception, no routes
            mk_known(32'hFFFF_FFFF, 1'b0, 32'h0, 4'h0, 6'd0),
            mk_write(4'd0, 1'b1, 32'h0, 32'h0, 32'h0A00_0001, 4'd1),       // default route
            mk_known(32'h0A00_0164, 1'b1, 32'h0A00_0001, 4'd1, 6'd0),
            mk_known(32'h0102_0304, 1'b0, 32'h0, 4'h0, 6'd0),   // default route miss
            mk_write(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15),
            mk_known(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'd15, 6'd32),
            mk_write(4'd3, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd2),
            mk_write(4'd2, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0B00_00FE, 4'd3),
            mk_lookup(32'h0A12_3456),                            // tie, lower slot
            mk_write(4'd7, 1'b1, 32'h0A12_0000, 32'hFFFF_0000, 32'hC0A8_0001, 4'd4),
            mk_lookup(32'h0A12_3456),
            mk_write(4'd8, 1'b1, 32'h0A00_3400, 32'hFF00_FF00, 32'h0A0A_0A0A, 4'd5),
            mk_lookup(32'h0A99_3412),                            // holey mask
            mk_write(4'd2, 1'b0, 32'h0A00_0000, 32'hFF00_0000, 32'h5555_5555, 4'd6),
            mk_lookup(32'h0A99_3412),                            // slot removed
            mk_write(4'd9, 1'b1, 32'h1234_5678, 32'h7FFF_FFFF, 32'h9999_9999, 4'd7),
            mk_lookup(32'h1234_5678),
            mk_exc(32'h1234_5678),
            mk_lookup(32'h1234_5678),
            mk_exc(32'h0000_0000),
            mk_known(32'h0000_0000, 1'b1, 32'h0A00_0001, 4'd1, 6'd0),
            mk_exc(32'hFFFF_FFFF),
            mk_known(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 4'd15, 6'd32),
            mk_lookup(32'h0000_0000),
            mk_lookup(32'h0A12_0001)
        };

        repeat (RESET_CYC) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_SET_EXC)
                write_exception(dir_tab[i].exc_value);
            else
            begin
                send_item(dir_tab[i].cmd, dir_tab[i].kind == ROW_LOOKUP_KNOWN,
                          dir_tab[i].known);
                if ($urandom_range(0, 99) < 35)
                    idle_gap();
            end
        end

        // Random phases, each under its own exception address
        total = PHASES * PHASE_ITEMS;
        sent  = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_exc = tab_dest[$urandom_range(0, INDEX_SLOTS - 1)];
                1:       phase_exc = 32'h0000_0000;
                2:       phase_exc = 32'hFFFF_FFFF;
                3:       phase_exc = EXCEPTION_RESET;
                default: phase_exc = $urandom;
            endcase
            write_exception(phase_exc);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                c = random_item();
                send_item(c, 1'b0, '0);
                sent++;
                if (sent < total - QUIET_TAIL && $urandom_range(0, 99) < 35)
                    idle_gap();
            end
        end

        drain_results();
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: longest_prefix_route_lookup.f
hdl/lprl_pkg.sv
hdl/lprl_ctrl.sv
hdl/lprl_datapath.sv
hdl/longest_prefix_route_lookup.sv
tb/tb_top.sv
